// ===== src/cidm_pkg.sv =====
package cidm_pkg;

    localparam int DATA_WIDTH   = 64;
    localparam int NARROW_WIDTH = 32;
    // radix-2 steps retired per pipeline stage
    localparam int STEPS_PER_STAGE = 4;
    localparam int DIV_STAGES   = DATA_WIDTH / STEPS_PER_STAGE;

    typedef logic [DATA_WIDTH-1:0] data_t;

    typedef enum logic
    {
        ACT_QUOTIENT  = 1'b0,
        ACT_REMAINDER = 1'b1
    } action_t;

    // control carried alongside the divide datapath
    typedef struct packed
    {
        logic    valid;
        action_t action;
        logic    wide;
        logic    neg_q;
        logic    neg_r;
        logic    bypass;
        logic    error;
    } ctl_t;

    // one stage slot of the restoring divider
    typedef struct packed
    {
        ctl_t  ctl;
        data_t rem;
        data_t quo;
        data_t dvs;
    } div_slot_t;

    function automatic div_slot_t div_steps(input div_slot_t s);
        div_slot_t o;
        logic [DATA_WIDTH:0] trial;
        o = s;
        for (int k = 0; k < STEPS_PER_STAGE; k++)
        begin
            trial = {o.rem, o.quo[DATA_WIDTH-1]} - {1'b0, o.dvs};
            if (!trial[DATA_WIDTH])
            begin
                o.rem = trial[DATA_WIDTH-1:0];
                o.quo = {o.quo[DATA_WIDTH-2:0], 1'b1};
            end
            else
            begin
                o.rem = {o.rem[DATA_WIDTH-2:0], o.quo[DATA_WIDTH-1]};
                o.quo = {o.quo[DATA_WIDTH-2:0], 1'b0};
            end
        end
        return o;
    endfunction

endpackage

// ===== src/cidm_front.sv =====
module cidm_front
(
    input  logic               action,
    input  logic               signed_mode,
    input  logic               wide_mode,
    input  cidm_pkg::data_t    dividend,
    input  cidm_pkg::data_t    divisor,
    input  logic               in_valid,
    output cidm_pkg::div_slot_t slot
);
    import cidm_pkg::*;

    data_t mask;
    data_t top;
    data_t a;
    data_t b;
    logic  na;
    logic  nb;
    logic  zero_div;
    logic  ovf;

    always_comb
    begin
        mask = wide_mode ? '1 : data_t'({NARROW_WIDTH{1'b1}});
        top  = wide_mode ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                         : data_t'({1'b1, {(NARROW_WIDTH-1){1'b0}}});
        a    = dividend & mask;
        b    = divisor & mask;
        na   = signed_mode && ((a & top) != '0);
        nb   = signed_mode && ((b & top) != '0);
        zero_div = (b == '0);
        ovf  = signed_mode && (action == ACT_QUOTIENT) && (a == top) && (b == mask);
        slot.ctl.valid  = in_valid;
        slot.ctl.action = action_t'(action);
        slot.ctl.wide   = wide_mode;
        slot.ctl.neg_q  = na ^ nb;
        slot.ctl.neg_r  = na;
        slot.ctl.bypass = zero_div || ovf;
        slot.ctl.error  = zero_div || ovf;
        slot.rem = '0;
        slot.quo = na ? ((~a + 1'b1) & mask) : a;
        slot.dvs = nb ? ((~b + 1'b1) & mask) : b;
    end
endmodule

// ===== src/cidm_stage.sv =====
module cidm_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  cidm_pkg::div_slot_t slot_in,
    output cidm_pkg::div_slot_t slot_reg
);
    import cidm_pkg::*;

    div_slot_t slot_next;
    div_slot_t data_reg;
    logic      valid_reg;

    always_comb
    begin
        slot_next = div_steps(slot_in);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= slot_in.ctl.valid;
        end
    end

    // payload carries no reset; only the valid bit does
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= slot_next;
        end
    end

    always_comb
    begin
        slot_reg           = data_reg;
        slot_reg.ctl.valid = valid_reg;
    end
endmodule

// ===== src/checked_integer_divide_modulo_unit.sv =====
// Channel  | Handshake                | Payload
// ---------+--------------------------+---------------------------------------------
// request  | in_valid / in_stall      | action, signed_mode, wide_mode, dividend, divisor
// result   | out_valid / out_stall    | result, error
//
// One request per cycle sustained while the result side is not stalled; the pipe has
// sixteen divider stages, four restoring steps each, plus the sign fix-up/output register.
// Reset clears only the valid bits. A stall on the result side holds the output and every stage
// with no empty stage after it; a bubble anywhere lets upstream requests advance into it.
module checked_integer_divide_modulo_unit
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 action,
    input  logic                 signed_mode,
    input  logic                 wide_mode,
    input  cidm_pkg::data_t      dividend,
    input  cidm_pkg::data_t      divisor,
    output logic                 out_valid,
    input  logic                 out_stall,
    output cidm_pkg::data_t      result,
    output logic                 error
);
    import cidm_pkg::*;

    div_slot_t slot [0:DIV_STAGES];
    logic      adv  [0:DIV_STAGES];
    logic      out_valid_reg;
    data_t     result_reg;
    logic      error_reg;
    logic      out_adv;
    data_t     res_next;
    data_t     q_fix;
    data_t     r_fix;
    data_t     mask_l;

    cidm_front u_front
    (
        .action      (action),
        .signed_mode (signed_mode),
        .wide_mode   (wide_mode),
        .dividend    (dividend),
        .divisor     (divisor),
        .in_valid    (in_valid),
        .slot        (slot[0])
    );

    // a stage moves when the one after it moves or it is empty
    assign out_adv = !out_valid_reg || !out_stall;

    always_comb
    begin
        adv[DIV_STAGES] = out_adv;
        for (int i = DIV_STAGES - 1; i >= 0; i--)
        begin
            adv[i] = adv[i+1] || !slot[i+1].ctl.valid;
        end
    end

    assign in_stall = !adv[0];

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_stage
        cidm_stage u_stage
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (adv[g]),
            .slot_in  (slot[g]),
            .slot_reg (slot[g+1])
        );
    end

    // sign fix-up, width trim and error override
    always_comb
    begin
        mask_l  = slot[DIV_STAGES].ctl.wide ? '1 : data_t'({NARROW_WIDTH{1'b1}});
        q_fix   = slot[DIV_STAGES].ctl.neg_q ? (~slot[DIV_STAGES].quo + 1'b1)
                                             : slot[DIV_STAGES].quo;
        r_fix   = slot[DIV_STAGES].ctl.neg_r ? (~slot[DIV_STAGES].rem + 1'b1)
                                             : slot[DIV_STAGES].rem;
        if (slot[DIV_STAGES].ctl.bypass)
        begin
            res_next = '0;
        end
        else
        begin
            res_next = ((slot[DIV_STAGES].ctl.action == ACT_REMAINDER) ? r_fix : q_fix)
                       & mask_l;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= slot[DIV_STAGES].ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv)
        begin
            result_reg <= res_next;
            error_reg  <= slot[DIV_STAGES].ctl.error;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;
    assign error     = error_reg;

`ifndef ASSERT_OFF
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> result == '0)
        else $error("error result not zero");
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result) && $stable(error))
        else $error("stalled result changed");
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled without output stall");
`endif
endmodule
